FILE: design/pfc_pkg.sv
// Shared types, codes and letter/slot helper functions for the Playfair cipher block.
`timescale 1ns / 1ps

package pfc_pkg;

  localparam logic [4:0] NUM_CELLS   = 5'd25;
  localparam logic [4:0] NUM_LETTERS = 5'd26;
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LAST_LETTER = 5'd25;

  typedef enum logic [2:0] {
    OP_CLEAR   = 3'd0,
    OP_KEY     = 3'd1,
    OP_FINISH  = 3'd2,
    OP_ENCRYPT = 3'd3,
    OP_DECRYPT = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_IGNORED    = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_CELL,
    S_FILL
  } state_t;

  // write into both lanes' copies of the square and slot tables
  typedef struct packed {
    logic       we;
    logic [4:0] letter;
    logic [4:0] slot;
  } lane_wr_t;

  // letters above z wrap onto a..f, then j folds onto i
  function automatic logic [4:0] pair_letter(input logic [4:0] raw);
    logic [4:0] v;
    v = (raw >= NUM_LETTERS) ? raw - NUM_LETTERS : raw;
    if (v == LETTER_J) begin
      v = LETTER_I;
    end
    return v;
  endfunction

  function automatic logic [2:0] slot_row(input logic [4:0] s);
    logic [2:0] r;
    if (s >= 5'd20) begin
      r = 3'd4;
    end else if (s >= 5'd15) begin
      r = 3'd3;
    end else if (s >= 5'd10) begin
      r = 3'd2;
    end else if (s >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  function automatic logic [2:0] slot_col(input logic [4:0] s);
    logic [2:0] r;
    logic [4:0] c;
    r = slot_row(s);
    c = s - ({2'b00, r} << 2) - {2'b00, r};
    return c[2:0];
  endfunction

  function automatic logic [4:0] slot_of(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  // one place on, modulo 5; back steps the other way
  function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic back);
    logic [2:0] n;
    if (back) begin
      n = (v == 3'd0) ? 3'd4 : v - 3'd1;
    end else begin
      n = (v == 3'd4) ? 3'd0 : v + 3'd1;
    end
    return n;
  endfunction

endpackage

FILE: design/pfc_lane.sv
// One lookup lane: own copy of the slot table and the key square, registered reads.
`timescale 1ns / 1ps

module pfc_lane (
  input  logic             clk,
  input  pfc_pkg::lane_wr_t wr,
  input  logic             slot_en,
  input  logic [4:0]       letter,
  output logic [4:0]       slot,
  input  logic [4:0]       cell_addr,
  output logic [4:0]       square_rd
);

  logic [4:0] slot_mem [26];
  logic [4:0] square_mem [25];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      slot_mem[wr.letter] <= wr.slot;
      square_mem[wr.slot] <= wr.letter;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_en) begin
      slot <= slot_mem[letter];
    end
  end

  always_ff @(posedge clk) begin
    square_rd <= square_mem[cell_addr];
  end

endmodule

FILE: design/pfc_merge.sv
// Merge stage: combines both lanes' slots into the two target cells of the digraph rule.
`timescale 1ns / 1ps

module pfc_merge (
  input  logic [4:0] slot_a,
  input  logic [4:0] slot_b,
  input  logic       decrypt,
  output logic [4:0] cell_a,
  output logic [4:0] cell_b
);

  logic [2:0] r1, c1, r2, c2;
  logic [2:0] nr1, nc1, nr2, nc2;

  always_comb begin
    r1  = pfc_pkg::slot_row(slot_a);
    c1  = pfc_pkg::slot_col(slot_a);
    r2  = pfc_pkg::slot_row(slot_b);
    c2  = pfc_pkg::slot_col(slot_b);
    nr1 = r1;
    nc1 = c1;
    nr2 = r2;
    nc2 = c2;
    if (r1 == r2) begin
      nc1 = pfc_pkg::wrap_step(c1, decrypt);
      nc2 = pfc_pkg::wrap_step(c2, decrypt);
    end else if (c1 == c2) begin
      nr1 = pfc_pkg::wrap_step(r1, decrypt);
      nr2 = pfc_pkg::wrap_step(r2, decrypt);
    end else begin
      // rectangle: trade columns
      nc1 = c2;
      nc2 = c1;
    end
    cell_a = pfc_pkg::slot_of(nr1, nc1);
    cell_b = pfc_pkg::slot_of(nr2, nc2);
  end

endmodule

FILE: design/playfair_digraph_cipher.sv
// Top level of the Playfair digraph cipher: command decode, square build and pair datapath.
`timescale 1ns / 1ps

// Usage
//   A request is taken when start is high and busy is low; opcode picks clear,
//   key letter, finish, encrypt or decrypt. Every request gives exactly one
//   result on out_first/out_second/status, marked by done for one cycle.
//   The receiver cannot stall; results must be taken in the cycle they appear.
// Timing
//   Clear, key letter, unused opcodes and pairs refused for an incomplete
//   square: done in the cycle after the request, busy stays low (1 per cycle).
//   Encrypt/decrypt: slot lookup in both lanes, then square read, then output
//   register before done; busy is high in S_SLOT and S_CELL, so a new pair is
//   taken only once the last is through (two registered table reads in series).
//   Finish on an incomplete square walks the alphabet one letter a cycle, done
//   after the last letter; on a complete square done comes in the cycle after the request.
// Reset
//   rst (synchronous) empties the square and returns to idle; no result is lost
//   other than one in flight.
module playfair_digraph_cipher (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] opcode,
  input  logic [4:0] first_letter,
  input  logic [4:0] second_letter,
  output logic       done,
  output logic [4:0] out_first,
  output logic [4:0] out_second,
  output logic [1:0] status
);

  pfc_pkg::state_t   state, state_next;
  logic [4:0]        fill, fill_next;
  logic [25:0]       present, present_next;
  logic [4:0]        walk, walk_next;
  logic              decrypt, decrypt_next;
  logic              done_next;
  logic [4:0]        out_first_next, out_second_next;
  logic [1:0]        status_next;
  pfc_pkg::lane_wr_t wr;
  logic              slot_en;
  logic              accept;
  logic              full;
  logic              key_taken;
  logic              walk_place;
  logic [4:0]        slot_a, slot_b, cell_addr_a, cell_addr_b, cell_a, cell_b;

  assign busy   = (state != pfc_pkg::S_IDLE);
  assign accept = start && !busy;
  assign full   = (fill == pfc_pkg::NUM_CELLS);

  always_comb begin
    key_taken = 1'b0;
    if (first_letter < pfc_pkg::NUM_LETTERS && first_letter != pfc_pkg::LETTER_J) begin
      key_taken = !present[first_letter] && !full;
    end
  end

  assign walk_place = (walk != pfc_pkg::LETTER_J) && !present[walk] && !full;

  pfc_lane u_lane_a (
    .clk       (clk),
    .wr        (wr),
    .slot_en   (slot_en),
    .letter    (pfc_pkg::pair_letter(first_letter)),
    .slot      (slot_a),
    .cell_addr (cell_addr_a),
    .square_rd (cell_a)
  );

  pfc_lane u_lane_b (
    .clk       (clk),
    .wr        (wr),
    .slot_en   (slot_en),
    .letter    (pfc_pkg::pair_letter(second_letter)),
    .slot      (slot_b),
    .cell_addr (cell_addr_b),
    .square_rd (cell_b)
  );

  pfc_merge u_merge (
    .slot_a  (slot_a),
    .slot_b  (slot_b),
    .decrypt (decrypt),
    .cell_a  (cell_addr_a),
    .cell_b  (cell_addr_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= pfc_pkg::S_IDLE;
      fill    <= '0;
      present <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      present <= present_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    walk       <= walk_next;
    decrypt    <= decrypt_next;
    out_first  <= out_first_next;
    out_second <= out_second_next;
    status     <= status_next;
  end

  always_comb begin
    state_next      = state;
    fill_next       = fill;
    present_next    = present;
    walk_next       = walk;
    decrypt_next    = decrypt;
    done_next       = 1'b0;
    out_first_next  = '0;
    out_second_next = '0;
    status_next     = pfc_pkg::ST_OK;
    wr              = '0;
    slot_en         = 1'b0;

    case (state)
      pfc_pkg::S_IDLE: begin
        if (accept) begin
          case (opcode)
            pfc_pkg::OP_CLEAR: begin
              present_next = '0;
              fill_next    = '0;
              done_next    = 1'b1;
            end
            pfc_pkg::OP_KEY: begin
              done_next = 1'b1;
              if (key_taken) begin
                wr.we                      = 1'b1;
                wr.letter                  = first_letter;
                wr.slot                    = fill;
                present_next[first_letter] = 1'b1;
                fill_next                  = fill + 5'd1;
              end else begin
                status_next = pfc_pkg::ST_IGNORED;
              end
            end
            pfc_pkg::OP_FINISH: begin
              if (full) begin
                done_next = 1'b1;
              end else begin
                walk_next  = '0;
                state_next = pfc_pkg::S_FILL;
              end
            end
            pfc_pkg::OP_ENCRYPT, pfc_pkg::OP_DECRYPT: begin
              if (full) begin
                slot_en      = 1'b1;
                decrypt_next = (opcode == pfc_pkg::OP_DECRYPT);
                state_next   = pfc_pkg::S_SLOT;
              end else begin
                done_next   = 1'b1;
                status_next = pfc_pkg::ST_INCOMPLETE;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      pfc_pkg::S_SLOT: begin
        // merged cell addresses go to both square copies this cycle
        state_next = pfc_pkg::S_CELL;
      end
      pfc_pkg::S_CELL: begin
        out_first_next  = cell_a;
        out_second_next = cell_b;
        done_next       = 1'b1;
        state_next      = pfc_pkg::S_IDLE;
      end
      pfc_pkg::S_FILL: begin
        if (walk_place) begin
          wr.we              = 1'b1;
          wr.letter          = walk;
          wr.slot            = fill;
          present_next[walk] = 1'b1;
          fill_next          = fill + 5'd1;
        end
        if (walk == pfc_pkg::LAST_LETTER) begin
          done_next  = 1'b1;
          state_next = pfc_pkg::S_IDLE;
        end else begin
          walk_next = walk + 5'd1;
        end
      end
      default: begin
        state_next = pfc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: sim/tb_playfair_digraph_cipher.sv
// Self-checking testbench for playfair_digraph_cipher: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_playfair_digraph_cipher;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_REQUESTS = 630;
  localparam int DRAIN_CYCLES = 40;
  localparam int DIRECTED_ROWS = 25;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam logic [4:0] L_A = 5'd0;
  localparam logic [4:0] L_B = 5'd1;
  localparam logic [4:0] L_D = 5'd3;
  localparam logic [4:0] L_E = 5'd4;
  localparam logic [4:0] L_P = 5'd15;
  localparam logic [4:0] L_Z = 5'd25;
  localparam logic [4:0] NOT_LETTER_LO = 5'd26;
  localparam logic [4:0] NOT_LETTER_HI = 5'd31;

  typedef struct packed {
    logic [4:0]       ltr_a;
    logic [4:0]       ltr_b;
    pfc_pkg::status_t st;
  } reply_t;

  localparam reply_t R_OK  = '{5'd0, 5'd0, pfc_pkg::ST_OK};
  localparam reply_t R_IGN = '{5'd0, 5'd0, pfc_pkg::ST_IGNORED};
  localparam reply_t R_INC = '{5'd0, 5'd0, pfc_pkg::ST_INCOMPLETE};

  typedef struct {
    logic [2:0] op;
    logic [4:0] a;
    logic [4:0] b;
    bit         typed;
    reply_t     reply;
  } directed_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] opcode = 3'd0;
  logic [4:0] first_letter = 5'd0;
  logic [4:0] second_letter = 5'd0;
  logic       busy;
  logic       done;
  logic [4:0] out_first;
  logic [4:0] out_second;
  logic [1:0] status;

  // predictor copy of the key square
  logic [4:0] sq_letter [0:24];
  logic [4:0] sq_slot_of [0:25];
  bit         sq_present [0:25];
  int         sq_fill = 0;

  reply_t     pending_replies [$];
  int         mismatch_count = 0;
  int         counted_requests = 0;
  int         quiet_cycles = 0;
  bit         burst_mode = 1'b0;

  directed_row_t directed_rows [0:DIRECTED_ROWS-1];

  playfair_digraph_cipher uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .first_letter (first_letter),
    .second_letter(second_letter),
    .done         (done),
    .out_first    (out_first),
    .out_second   (out_second),
    .status       (status)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void place_in_square(input int letter);
    if (sq_fill < 25) begin
      sq_letter[sq_fill] = 5'(letter);
      sq_slot_of[letter] = 5'(sq_fill);
      sq_present[letter] = 1'b1;
      sq_fill++;
    end
  endfunction

  // j folds onto i; values above z wrap onto a..f first
  function automatic int fold_letter(input logic [4:0] raw);
    int v;
    v = int'(raw) % 26;
    if (v == int'(pfc_pkg::LETTER_J)) begin
      v = int'(pfc_pkg::LETTER_I);
    end
    return v;
  endfunction

  function automatic reply_t playfair_step(input logic [2:0] op, input logic [4:0] a,
                                           input logic [4:0] b);
    reply_t r;
    int     k, s1, s2, r1, c1, r2, c2, stp, t;
    r = R_OK;
    case (op)
      pfc_pkg::OP_CLEAR: begin
        foreach (sq_present[i]) sq_present[i] = 1'b0;
        sq_fill = 0;
      end
      pfc_pkg::OP_KEY: begin
        if (a >= pfc_pkg::NUM_LETTERS || a == pfc_pkg::LETTER_J ||
            sq_present[a] || sq_fill >= 25) begin
          r.st = pfc_pkg::ST_IGNORED;
        end else begin
          place_in_square(int'(a));
        end
      end
      pfc_pkg::OP_FINISH: begin
        for (k = 0; k < 26; k++) begin
          if (k != int'(pfc_pkg::LETTER_J) && !sq_present[k]) begin
            place_in_square(k);
          end
        end
      end
      pfc_pkg::OP_ENCRYPT, pfc_pkg::OP_DECRYPT: begin
        if (sq_fill < 25) begin
          r.st = pfc_pkg::ST_INCOMPLETE;
        end else begin
          s1 = int'(sq_slot_of[fold_letter(a)]) % 25;
          s2 = int'(sq_slot_of[fold_letter(b)]) % 25;
          r1 = s1 / 5;
          c1 = s1 % 5;
          r2 = s2 / 5;
          c2 = s2 % 5;
          stp = (op == pfc_pkg::OP_ENCRYPT) ? 1 : 4;
          if (r1 == r2) begin
            c1 = (c1 + stp) % 5;
            c2 = (c2 + stp) % 5;
          end else if (c1 == c2) begin
            r1 = (r1 + stp) % 5;
            r2 = (r2 + stp) % 5;
          end else begin
            t = c1;
            c1 = c2;
            c2 = t;
          end
          r.ltr_a = sq_letter[r1 * 5 + c1];
          r.ltr_b = sq_letter[r2 * 5 + c2];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic log_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic issue(input logic [2:0] op, input logic [4:0] a, input logic [4:0] b,
                       input bit use_typed = 1'b0, input reply_t typed_reply = R_OK);
    reply_t predicted;
    int     gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start         <= 1'b1;
    opcode        <= op;
    first_letter  <= a;
    second_letter <= b;
    do @(posedge clk); while (busy);
    predicted = playfair_step(op, a, b);
    pending_replies.push_back(use_typed ? typed_reply : predicted);
    if (op <= pfc_pkg::OP_DECRYPT && predicted.st != pfc_pkg::ST_IGNORED) begin
      counted_requests++;
    end
  endtask

  task automatic send_pairs(input int n);
    logic [4:0] a;
    logic [4:0] b;
    logic [2:0] op;
    repeat (n) begin
      op = $urandom_range(0, 1) ? pfc_pkg::OP_ENCRYPT : pfc_pkg::OP_DECRYPT;
      a  = 5'($urandom_range(0, 31));
      b  = ($urandom_range(0, 7) == 0) ? a : 5'($urandom_range(0, 31));
      issue(op, a, b);
    end
  endtask

  // mostly real letters, now and then a code above z
  task automatic send_keys(input int n);
    logic [4:0] k;
    repeat (n) begin
      k = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 25));
      issue(pfc_pkg::OP_KEY, k, 5'($urandom_range(0, 31)));
    end
  endtask

  task automatic run_random_traffic();
    int kind, i, j, t;
    int order [0:25];
    while (counted_requests < RANDOM_REQUESTS) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        issue(pfc_pkg::OP_CLEAR, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        send_keys($urandom_range(0, 12));
        issue(pfc_pkg::OP_FINISH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        send_pairs($urandom_range(4, 30));
      end else if (kind == 6) begin
        // whole alphabet keyed in shuffled order, so finish finds the square full
        for (i = 0; i < 26; i++) order[i] = i;
        for (i = 25; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = order[i];
          order[i] = order[j];
          order[j] = t;
        end
        issue(pfc_pkg::OP_CLEAR, 5'd0, 5'd0);
        for (i = 0; i < 26; i++) begin
          issue(pfc_pkg::OP_KEY, 5'(order[i]), 5'($urandom_range(0, 31)));
        end
        send_keys($urandom_range(1, 3));
        issue(pfc_pkg::OP_FINISH, 5'd0, 5'd0);
        send_pairs($urandom_range(4, 20));
      end else if (kind == 7) begin
        // pairs sent into a half-built square
        issue(pfc_pkg::OP_CLEAR, 5'd0, 5'd0);
        send_keys($urandom_range(0, 6));
        send_pairs($urandom_range(1, 4));
        if ($urandom_range(0, 1)) issue(pfc_pkg::OP_FINISH, 5'd0, 5'd0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          issue(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                5'($urandom_range(0, 31)));
        end
      end
    end
  endtask

  // result checker: a done with nothing pending is a failure too
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done) begin
      if (pending_replies.size() == 0) begin
        log_mismatch("unrequested result, status", int'(status), 0);
      end else begin
        want = pending_replies.pop_front();
        if (out_first !== want.ltr_a) log_mismatch("out_first", int'(out_first), int'(want.ltr_a));
        if (out_second !== want.ltr_b) begin
          log_mismatch("out_second", int'(out_second), int'(want.ltr_b));
        end
        if (status !== want.st) log_mismatch("status", int'(status), int'(want.st));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    // square after finish with key p, a, z:
    //   p a z b c / d e f g h / i k l m n / o q r s t / u v w x y
    directed_rows = '{
      '{pfc_pkg::OP_ENCRYPT, L_A,               L_B,               1'b1, R_INC},
      '{pfc_pkg::OP_DECRYPT, L_Z,               L_Z,               1'b1, R_INC},
      '{OP_SPARE_LO,         L_A,               L_A,               1'b1, R_OK},
      '{OP_SPARE_HI,         NOT_LETTER_HI,     NOT_LETTER_HI,     1'b1, R_OK},
      '{pfc_pkg::OP_KEY,     NOT_LETTER_HI,     L_A,               1'b1, R_IGN},
      '{pfc_pkg::OP_KEY,     NOT_LETTER_LO,     L_A,               1'b1, R_IGN},
      '{pfc_pkg::OP_KEY,     pfc_pkg::LETTER_J, L_A,               1'b1, R_IGN},
      '{pfc_pkg::OP_CLEAR,   L_A,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_KEY,     L_P,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_KEY,     L_P,               L_A,               1'b1, R_IGN},
      '{pfc_pkg::OP_KEY,     L_A,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_KEY,     L_Z,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_ENCRYPT, L_P,               L_A,               1'b1, R_INC},
      '{pfc_pkg::OP_FINISH,  L_A,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_FINISH,  L_A,               L_A,               1'b1, R_OK},
      '{pfc_pkg::OP_KEY,     L_B,               L_A,               1'b1, R_IGN},
      '{pfc_pkg::OP_ENCRYPT, L_P,               L_A,               1'b0, R_OK},
      '{pfc_pkg::OP_ENCRYPT, L_P,               L_D,               1'b0, R_OK},
      '{pfc_pkg::OP_ENCRYPT, L_P,               L_E,               1'b0, R_OK},
      '{pfc_pkg::OP_DECRYPT, L_P,               L_A,               1'b0, R_OK},
      '{pfc_pkg::OP_DECRYPT, L_P,               L_D,               1'b0, R_OK},
      '{pfc_pkg::OP_ENCRYPT, L_A,               L_A,               1'b0, R_OK},
      '{pfc_pkg::OP_ENCRYPT, pfc_pkg::LETTER_J, pfc_pkg::LETTER_I, 1'b0, R_OK},
      '{pfc_pkg::OP_DECRYPT, NOT_LETTER_HI,     NOT_LETTER_LO,     1'b0, R_OK},
      '{pfc_pkg::OP_ENCRYPT, L_Z,               L_A,               1'b0, R_OK}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      burst_mode = (n >= 16);
      issue(directed_rows[n].op, directed_rows[n].a, directed_rows[n].b,
            directed_rows[n].typed, directed_rows[n].reply);
    end

    run_random_traffic();
    @(negedge clk);
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: files.f
design/pfc_pkg.sv
design/pfc_lane.sv
design/pfc_merge.sv
design/playfair_digraph_cipher.sv
sim/tb_playfair_digraph_cipher.sv
